// ===== rtl/dasf_pkg.sv =====
// ============================================================================
// dasf_pkg
// shared types and constants for the dual audio sample fifo
// ============================================================================
package dasf_pkg;

    // dma register width and the base of the two fifo port addresses
    localparam int unsigned DEST_W = 28;
    localparam logic [DEST_W-1:0] FIFO_PORT_BASE = 28'h40000A0;

    localparam int unsigned WORD_W = 32;

    // input kind codes carried on tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SEND = 3'b100
    } dasf_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic capture;  // latch ram read data into the output word
    } dasf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_hit;  // offered word is a pop of a non-empty fifo
    } dasf_status_t;

endpackage

// ===== rtl/dasf_ram.sv =====
// ============================================================================
// dasf_ram
// generic single write, single read ram with registered read data
// ============================================================================
module dasf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dasf_ctrl.sv =====
// ============================================================================
// dasf_ctrl
// handshake sequencer: take a word, wait on the ram read, offer the result
// ============================================================================
module dasf_ctrl
    import dasf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  dasf_status_t status,
    output dasf_cmd_t    cmd
);

    dasf_state_t state_reg;
    dasf_state_t state_next;
    logic        accept;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = (state_reg == ST_SEND);
    assign accept      = s_tvalid & s_tready;
    assign cmd.accept  = accept;
    assign cmd.capture = (state_reg == ST_READ);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.pop_hit ? ST_READ : ST_SEND;
                end
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/dasf_dp.sv =====
// ============================================================================
// dasf_dp
// ring pointers, fill counts, dma register, sample ram and result register
// ============================================================================
module dasf_dp
    import dasf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH   = 8,
    parameter int unsigned REFILL_LEVEL = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DEST_W-1:0] cfg_wdata,
    input  logic [WORD_W-1:0] s_tdata,
    input  logic [1:0]        s_tuser,
    output logic [WORD_W-1:0] m_tdata,
    output logic [2:0]        m_tuser,
    input  dasf_cmd_t         cmd,
    output dasf_status_t      status
);

    localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
    localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned ADDR_W = PTR_W + 1;
    localparam int unsigned CMP_W  = 7;

    logic [FILL_W-1:0] fill_reg [2];
    logic [PTR_W-1:0]  rptr_reg [2];
    logic [DEST_W-1:0] dest_reg;
    logic [WORD_W-1:0] word_reg;
    logic [2:0]        flags_reg;

    logic              op;
    logic              ch;
    logic [FILL_W-1:0] fill;
    logic [PTR_W-1:0]  rptr;
    logic              is_full;
    logic              is_empty;
    logic              low_level;
    logic              dma1_hit;
    logic [ADDR_W-1:0] wsum;
    logic [PTR_W-1:0]  wpos;
    logic [PTR_W-1:0]  rptr_inc;
    logic [ADDR_W-1:0] ch_base;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              do_push;
    logic              do_pop;
    logic [WORD_W-1:0] ram_rdata;

    assign op   = s_tuser[0];
    assign ch   = s_tuser[1];
    assign fill = fill_reg[ch];
    assign rptr = rptr_reg[ch];

    assign is_full   = (fill == FILL_W'(FIFO_DEPTH));
    assign is_empty  = (fill == '0);
    assign low_level = (CMP_W'(fill) <= CMP_W'(REFILL_LEVEL));
    assign dma1_hit  = (dest_reg == (FIFO_PORT_BASE + {{(DEST_W-3){1'b0}}, ch, 2'b00}));

    // write slot is read pointer plus fill, wrapped once
    assign wsum = ADDR_W'(rptr) + ADDR_W'(fill);
    assign wpos = (wsum >= ADDR_W'(FIFO_DEPTH)) ? PTR_W'(wsum - ADDR_W'(FIFO_DEPTH))
                                                : PTR_W'(wsum);
    assign rptr_inc = (rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;

    // channel b occupies the upper half of the ram
    assign ch_base = ch ? ADDR_W'(FIFO_DEPTH) : '0;
    assign waddr   = ch_base + ADDR_W'(wpos);
    assign raddr   = ch_base + ADDR_W'(rptr);

    assign do_push = cmd.accept & (op == OP_PUSH) & ~is_full;
    assign do_pop  = cmd.accept & (op == OP_POP) & ~is_empty;

    assign status.pop_hit = (op == OP_POP) & ~is_empty;

    dasf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (2 * FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (waddr),
        .wdata (s_tdata),
        .re    (do_pop),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
            rptr_reg[0] <= '0;
            rptr_reg[1] <= '0;
            dest_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dest_reg <= cfg_wdata;
            end
            if (do_push)
            begin
                fill_reg[ch] <= fill + 1'b1;
            end
            if (do_pop)
            begin
                fill_reg[ch] <= fill - 1'b1;
                rptr_reg[ch] <= rptr_inc;
            end
        end
    end

    // result register: flags set and word cleared at accept, word filled in from the ram for a non-empty pop
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            word_reg <= '0;
            if (op == OP_PUSH)
            begin
                flags_reg <= {is_full, 2'b00};
            end
            else
            begin
                flags_reg <= {1'b0, low_level & ~dma1_hit, low_level};
            end
        end
        else if (cmd.capture)
        begin
            word_reg <= ram_rdata;
        end
    end

    assign m_tdata = word_reg;
    assign m_tuser = flags_reg;

endmodule

// ===== rtl/dual_audio_sample_fifo_top.sv =====
// ============================================================================
// dual_audio_sample_fifo_top
// two independent sample fifos (channel a and b) with dma refill requests
// ============================================================================
//
//   group   dir  tdata                tuser
//   s_*     in   sample_word [31:0]   operation [0], channel [1]
//   m_*     out  popped_word [31:0]   refill_request [0], refill_unit [1],
//                                     push_dropped [2]
//   cfg_*   in   dma1_destination [27:0], written when cfg_we is high
//
// one word at a time: a push or an empty pop shows its result the cycle after
// acceptance; a pop of a non-empty fifo first passes through the read state, as
// it waits on the registered read port of the sample ram. s_tready is high
// again the cycle after the result is taken.
// rst_n clears fill counts, read pointers and the dma register; the ram
// holds no reset contents and needs no clearing pass.
// a stalled m_tready holds the result and keeps s_tready low.
//
module dual_audio_sample_fifo_top
    import dasf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH   = 8,   // entries per channel, 2..64
    parameter int unsigned REFILL_LEVEL = 4    // pop at this fill or less requests dma
) (
    input  logic              clk,
    input  logic              rst_n,

    // dma1 destination register
    input  logic              cfg_we,
    input  logic [DEST_W-1:0] cfg_wdata,

    // input words
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,   // sample_word
    input  logic [1:0]        s_tuser,   // [0] operation, [1] channel

    // result words
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,   // popped_word
    output logic [2:0]        m_tuser    // [0] refill_request, [1] refill_unit,
                                         // [2] push_dropped
);

    dasf_cmd_t    cmd;     // accept / capture strobes from the sequencer
    dasf_status_t status;  // tells the sequencer whether a ram read is due

    dasf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dasf_dp #(
        .FIFO_DEPTH   (FIFO_DEPTH),
        .REFILL_LEVEL (REFILL_LEVEL)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
